// ----- sv/mrdc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the character-to-digit decoder for the
// minimum-radix detector and converter. No dependencies.

package mrdc_pkg;

    // Digit buffer depth and derived widths
    localparam int MAX_DIGITS = 64;
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int LEN_W      = $clog2(MAX_DIGITS + 2);

    // Fixed field widths
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 6;
    localparam int BASE_W  = 6;
    localparam int VALUE_W = 31;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = {VALUE_W{1'b1}};
    localparam logic [BASE_W-1:0]  BASE_MAX    = BASE_W'(36);

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] LETTER_BASE  = 8'd10;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD      = 2'd1,
        STATUS_OVERFLOW = 2'd2,
        STATUS_TOO_LONG = 2'd3
    } status_t;

    // Input transaction
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              end_of_token;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } out_item_t;

    // Decoded character
    typedef struct packed {
        logic               bad;
        logic [DIGIT_W-1:0] value;
    } digit_t;

    // Map an ASCII byte to a digit; a non-alphanumeric byte is flagged bad
    // and reads as digit zero.
    function automatic digit_t map_digit(input logic [CHAR_W-1:0] c);
        digit_t d;
        d.bad   = 1'b0;
        d.value = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d.value = DIGIT_W'(c - CHAR_ZERO);
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d.value = DIGIT_W'(c - CHAR_UPPER_A + LETTER_BASE);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d.value = DIGIT_W'(c - CHAR_LOWER_A + LETTER_BASE);
        end else begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

endpackage

// ----- sv/min_radix_detect_and_convert.sv -----
`timescale 1ns / 1ps
// Minimum-radix detector and converter: digit buffer memory, token tracking
// and the Horner evaluation loop. Depends on mrdc_pkg.
//
// Usage: the char channel (char_valid, char_stall, char_data) carries one
// character per transaction, with end_of_token set on the token's last one.
// The res channel (res_valid, res_stall, res_data) carries one result per
// token: base, value and status.
// Characters are taken one per cycle, except while char_stall is high, and
// written into a 64-entry digit memory while the largest digit is tracked.
// After the last character of a valid token the block reads the memory back
// one digit per cycle through a registered read port and applies one Horner
// step (multiply by base, add digit) per cycle on the registered digit. A
// token with a bad character or too many characters skips evaluation.
// char_stall is high during evaluation and result hand-off only.
// The result register holds a finished transaction while res_stall is high;
// the next token's characters are still taken meanwhile, and only the next
// result waits for the register to free.
// Reset empties the token and the result register; the digit memory is not
// cleared, as every entry is written before it is read.

module min_radix_detect_and_convert
    import mrdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    input  in_item_t  char_data,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_data
);

    typedef enum logic [2:0] {
        ST_ACCEPT = 3'b001,
        ST_EVAL   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [DIGIT_W-1:0] largest_reg, largest_next;
    logic               bad_reg, bad_next;
    logic [LEN_W-1:0]   iss_reg, iss_next;
    logic               rvalid_reg, rvalid_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    status_t            status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] rdata_reg;
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [DIGIT_W-1:0] wr_data;

    digit_t                     dig;
    logic                       char_take;
    logic [BASE_W-1:0]          base;
    logic [VALUE_W+BASE_W-1:0]  prod;
    logic [VALUE_W+BASE_W:0]    sum;
    logic                       step_ovf;
    logic                       out_free;

    assign dig       = map_digit(char_data.character);
    assign char_stall = (state_reg != ST_ACCEPT);
    assign char_take = char_valid && !char_stall;
    assign base      = BASE_W'(largest_reg) + BASE_W'(1);
    assign out_free  = !out_valid_reg || !res_stall;

    // One Horner step on the registered read data
    assign prod     = (VALUE_W + BASE_W)'(acc_reg) * (VALUE_W + BASE_W)'(base);
    assign sum      = {1'b0, prod} + (VALUE_W + BASE_W + 1)'(rdata_reg);
    assign step_ovf = sum > (VALUE_W + BASE_W + 1)'(VALUE_LIMIT);

    // Digit memory ports
    assign wr_en   = char_take && (len_reg < LEN_W'(MAX_DIGITS));
    assign wr_addr = len_reg[ADDR_W-1:0];
    assign wr_data = dig.value;
    assign rd_en   = (state_reg == ST_EVAL) && (iss_reg < len_reg);
    assign rd_addr = iss_reg[ADDR_W-1:0];

    // Write digits as they arrive
    always_ff @(posedge clk) begin
        if (wr_en) begin
            digit_mem[wr_addr] <= wr_data;
        end
    end

    // Read digits back for evaluation
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rdata_reg <= digit_mem[rd_addr];
        end
    end

    // Next-state logic
    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        largest_next   = largest_reg;
        bad_next       = bad_reg;
        iss_next       = iss_reg;
        rvalid_next    = 1'b0;
        acc_next       = acc_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_ACCEPT: begin
                if (char_take) begin
                    // Track the token
                    if (dig.bad) begin
                        bad_next = 1'b1;
                    end else if (dig.value > largest_reg) begin
                        largest_next = dig.value;
                    end
                    if (len_reg < LEN_W'(MAX_DIGITS)) begin
                        len_next = len_reg + LEN_W'(1);
                    end else begin
                        len_next = LEN_W'(MAX_DIGITS + 1);
                    end
                    // Close the token on its last character
                    if (char_data.end_of_token) begin
                        iss_next = '0;
                        acc_next = '0;
                        if (len_next > LEN_W'(MAX_DIGITS)) begin
                            status_next = STATUS_TOO_LONG;
                            state_next  = ST_RESULT;
                        end else if (bad_next) begin
                            status_next = STATUS_BAD;
                            state_next  = ST_RESULT;
                        end else begin
                            status_next = STATUS_OK;
                            state_next  = ST_EVAL;
                        end
                    end
                end
            end

            ST_EVAL: begin
                // Issue the next read
                if (rd_en) begin
                    iss_next    = iss_reg + LEN_W'(1);
                    rvalid_next = 1'b1;
                end
                // Consume the digit read last cycle
                if (rvalid_reg) begin
                    acc_next = sum[VALUE_W-1:0];
                    if (step_ovf) begin
                        status_next = STATUS_OVERFLOW;
                    end
                    if (iss_reg == len_reg) begin
                        state_next = ST_RESULT;
                    end
                end
            end

            ST_RESULT: begin
                // Load the result register once it is free, then clear the token
                if (out_free) begin
                    out_valid_next       = 1'b1;
                    out_data_next.base   = base;
                    out_data_next.value  = (status_reg == STATUS_OK) ? acc_reg : '0;
                    out_data_next.status = status_reg;
                    len_next             = '0;
                    largest_next         = '0;
                    bad_next             = 1'b0;
                    state_next           = ST_ACCEPT;
                end
            end

            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_ACCEPT;
            len_reg       <= '0;
            largest_reg   <= '0;
            bad_reg       <= 1'b0;
            iss_reg       <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            largest_reg   <= largest_next;
            bad_reg       <= bad_next;
            iss_reg       <= iss_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        acc_reg      <= acc_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // Reads never run past the buffered digits
    a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |-> iss_reg <= len_reg)
        else $error("read index passed token length");

    // Evaluation only runs on a clean token that fits the buffer
    a_eval_token: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |-> (!bad_reg && len_reg != '0
                                  && len_reg <= LEN_W'(MAX_DIGITS)))
        else $error("evaluation of an invalid token");

    // A new result is only loaded from the result state
    a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_RESULT))
        else $error("result loaded outside result state");

    // Value is zero unless the status is ok
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.status != STATUS_OK) |-> res_data.value == '0)
        else $error("non-zero value with error status");

    // Base stays within one to thirty-six
    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.base != '0 && res_data.base <= BASE_MAX))
        else $error("base out of range");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for min_radix_detect_and_convert: a clocked driver, a
// clocked monitor and a token predictor that checks base, value and status.
// Depends on mrdc_pkg and the block's RTL.

module tb_top;
    import mrdc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 100;
    localparam int RANDOM_CHARS = 2000;
    localparam int IDLE_PCT     = 36;
    localparam int QUIET_START  = 2000;
    localparam int QUIET_END    = 3500;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      char_valid = 1'b0;
    logic      char_stall;
    in_item_t  char_data = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_item_t res_data;

    // Characters waiting to be sent; a set flag holds the character back
    // until every outstanding result has come
    in_item_t  char_feed[$];
    bit        drain_flags[$];
    out_item_t expected_results[$];
    out_item_t next_expected;

    // Predictor copy of the token state
    logic [DIGIT_W-1:0] digit_buf[MAX_DIGITS];
    int                 tok_len = 0;
    logic [DIGIT_W-1:0] top_digit = '0;
    bit                 saw_bad = 1'b0;

    int   ends_sent = 0;
    int   results_seen = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   gen_chars = 0;
    logic quiet;

    assign quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

    min_radix_detect_and_convert uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    // Clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Digit of an ASCII byte, or -1 for a byte that is no digit
    function automatic int digit_of(input logic [CHAR_W-1:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "A" && c <= "Z")
            return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "z")
            return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    // Character for a digit, letters in either case
    function automatic logic [CHAR_W-1:0] char_of(input int d);
        if (d < 10)
            return CHAR_W'(int'("0") + d);
        if ($urandom_range(0, 1) == 0)
            return CHAR_W'(int'("A") + d - 10);
        return CHAR_W'(int'("a") + d - 10);
    endfunction

    function automatic logic [CHAR_W-1:0] random_bad_char();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(0, 255));
        while (digit_of(c) >= 0);
        return c;
    endfunction

    // Fold one accepted character into the token; on its last character
    // evaluate by Horner's rule and queue the result
    task automatic absorb_char(input in_item_t it);
        int          d;
        int          i;
        logic [63:0] acc;
        status_t     st;
        out_item_t   r;
        d = digit_of(it.character);
        if (d < 0) begin
            saw_bad = 1'b1;
            d = 0;
        end else if (d > top_digit) begin
            top_digit = DIGIT_W'(d);
        end
        if (tok_len < MAX_DIGITS) begin
            digit_buf[tok_len] = DIGIT_W'(d);
            tok_len++;
        end else begin
            tok_len = MAX_DIGITS + 1;
        end
        if (it.end_of_token) begin
            r.base = BASE_W'(top_digit + 1);
            st = STATUS_OK;
            acc = '0;
            if (tok_len > MAX_DIGITS) begin
                st = STATUS_TOO_LONG;
            end else if (saw_bad) begin
                st = STATUS_BAD;
            end else begin
                for (i = 0; i < tok_len; i++) begin
                    acc = acc * r.base + digit_buf[i];
                    if (acc > VALUE_LIMIT) begin
                        st = STATUS_OVERFLOW;
                        break;
                    end
                end
            end
            if (st != STATUS_OK)
                acc = '0;
            r.value = acc[VALUE_W-1:0];
            r.status = st;
            expected_results.push_back(r);
            tok_len = 0;
            top_digit = '0;
            saw_bad = 1'b0;
        end
    endtask

    task automatic queue_char(input logic [CHAR_W-1:0] c, input bit last, input bit drain);
        in_item_t it;
        it.character = c;
        it.end_of_token = last;
        char_feed.push_back(it);
        drain_flags.push_back(drain);
        gen_chars++;
    endtask

    task automatic queue_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_char(s[i], i == s.len() - 1, 1'b0);
    endtask

    // Well-formed token in a random base, with an optional bad character
    // and a forced largest digit
    task automatic queue_token(input int len, input bit with_bad, input bit drain);
        int b;
        int i;
        int bad_pos;
        int top_pos;
        logic [CHAR_W-1:0] c;
        b = $urandom_range(1, 36);
        bad_pos = with_bad ? $urandom_range(0, len - 1) : -1;
        top_pos = $urandom_range(0, len - 1);
        for (i = 0; i < len; i++) begin
            if (i == bad_pos)
                c = random_bad_char();
            else if (i == top_pos)
                c = char_of(b - 1);
            else
                c = char_of($urandom_range(0, b - 1));
            queue_char(c, i == len - 1, drain && i == 0);
        end
    endtask

    // Driver: hold a presented transaction until taken, then idle or send
    always @(posedge clk)
    begin
        bit taken;
        int ends_now;
        taken = char_valid && !char_stall;
        ends_now = ends_sent;
        if (rst_n) begin
            if (taken) begin
                absorb_char(char_data);
                if (char_data.end_of_token) begin
                    ends_now = ends_sent + 1;
                    ends_sent <= ends_now;
                end
            end
            if (!char_valid || taken) begin
                if (char_feed.size() != 0
                    && !(drain_flags[0] && ends_now != results_seen)
                    && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    char_data <= char_feed.pop_front();
                    void'(drain_flags.pop_front());
                    char_valid <= 1'b1;
                end else begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (res_valid && !res_stall) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result with nothing expected, got %p", $time, res_data);
                    mismatch_count++;
                end else begin
                    next_expected = expected_results.pop_front();
                    if (next_expected.base !== res_data.base) begin
                        $display("%0t ns: base expected %0d got %0d",
                                 $time, next_expected.base, res_data.base);
                        mismatch_count++;
                    end
                    if (next_expected.value !== res_data.value) begin
                        $display("%0t ns: value expected %0d got %0d",
                                 $time, next_expected.value, res_data.value);
                        mismatch_count++;
                    end
                    if (next_expected.status !== res_data.status) begin
                        $display("%0t ns: status expected %0d got %0d",
                                 $time, next_expected.status, res_data.status);
                        mismatch_count++;
                    end
                end
            end
            res_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Build the stimulus, release reset, then wait for the last result
    initial
    begin
        int i;
        int kind;
        int len;
        int tokens;

        // Directed: all zeros, binary, top of base 36, bad bytes at both
        // ends of the byte range, the largest value and one past it
        queue_string("0");
        queue_string("101");
        queue_string("Zz");
        queue_char(8'h00, 1'b0, 1'b0);
        queue_char("5", 1'b1, 1'b0);
        queue_char(8'hFF, 1'b1, 1'b0);
        queue_string("zik0zj");
        queue_string("ZIK0ZK");
        queue_string("a9");

        // Full-length token, then one character too many, with and
        // without a bad character past the stored part
        for (i = 0; i < MAX_DIGITS; i++)
            queue_char(i == MAX_DIGITS - 1 ? "1" : "0", i == MAX_DIGITS - 1, i == 0);
        for (i = 0; i <= MAX_DIGITS; i++)
            queue_char(char_of($urandom_range(0, 35)), i == MAX_DIGITS, 1'b0);
        for (i = 0; i <= MAX_DIGITS; i++)
            queue_char(i == MAX_DIGITS ? random_bad_char() : "7", i == MAX_DIGITS, 1'b0);

        // Random tokens: mostly well-formed, some with bad bytes, a few
        // long ones and some raw noise
        tokens = 0;
        gen_chars = 0;
        while (gen_chars < RANDOM_CHARS) begin
            kind = $urandom_range(0, 99);
            tokens++;
            if (kind < 2) begin
                queue_token($urandom_range(MAX_DIGITS - 4, MAX_DIGITS + 6),
                            $urandom_range(0, 3) == 0, 1'b0);
            end else if (kind < 7) begin
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                    queue_char(CHAR_W'($urandom_range(0, 255)), i == len - 1, 1'b0);
            end else begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14)
                                                  : $urandom_range(1, 8);
                queue_token(len, kind < 19, tokens % 80 == 0);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Sample on the falling edge, once the driver and monitor have settled
        while (char_feed.size() != 0 || char_valid)
            @(negedge clk);
        while (ends_sent != results_seen)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
